>>> hdl/tppf_pkg.sv
// shared types and constants for the page framebuffer with character generator
// no dependencies

package tppf_pkg;

  // default panel geometry and font store depth
  localparam int PANEL_WIDTH_DEF    = 128;
  localparam int PANEL_HEIGHT_DEF   = 64;
  localparam int MAX_GLYPH_ROWS_DEF = 32;

  // printable codes held in the font store
  localparam int GLYPH_COUNT = 95;

  // field widths
  localparam int CMD_W   = 4;
  localparam int POS_W   = 8;
  localparam int CHAR_W  = 8;
  localparam int FADDR_W = 12;
  localparam int FBITS_W = 16;
  localparam int BADDR_W = 10;
  localparam int CODE_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int FW_W    = 5;
  localparam int FH_W    = 6;

  // glyph row index before range check: (code - 32) * height + row, height < 64
  localparam int IDX_W = 13;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FONT_WIDTH_RST  = 5'd7;
  localparam logic [FH_W-1:0] FONT_HEIGHT_RST = 6'd10;

  // character codes
  localparam logic [CODE_W-1:0] CODE_FIRST = 7'd32;
  localparam logic [CODE_W-1:0] CODE_LAST  = 7'd126;
  localparam logic [CODE_W-1:0] CODE_SUBST = 7'd63;

  // leftmost pixel of a glyph row
  localparam logic [FBITS_W-1:0] ROW_MSB = 16'h8000;

  // commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 4'd0,
    CMD_FILL      = 4'd1,
    CMD_PIXEL_ON  = 4'd2,
    CMD_PIXEL_OFF = 4'd3,
    CMD_CURSOR    = 4'd4,
    CMD_CHAR      = 4'd5,
    CMD_NEWLINE   = 4'd6,
    CMD_SPACE     = 4'd7,
    CMD_FONT_LOAD = 4'd8,
    CMD_READ      = 4'd9
  } cmd_t;

  // control from the sequencer to the frame store
  typedef struct packed {
    logic       rd_en;
    logic       pix_vld;
    logic       pix_on;
    logic [2:0] pix_bit;
    logic       sweep_start;
    logic       sweep_fill;
  } frm_ctl_t;

endpackage

>>> hdl/tppf_if.sv
// valid/ready channel interfaces for the command and result items
// depends on tppf_pkg

interface tppf_in_if import tppf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [POS_W-1:0]     pos_x;
  logic [POS_W-1:0]     pos_y;
  logic [CHAR_W-1:0]    character;
  logic [FADDR_W-1:0]   font_address;
  logic [FBITS_W-1:0]   font_bits;
  logic [BADDR_W-1:0]   byte_address;

  modport source (output valid, command, pos_x, pos_y, character, font_address,
                  font_bits, byte_address, input ready);
  modport sink   (input valid, command, pos_x, pos_y, character, font_address,
                  font_bits, byte_address, output ready);
endinterface

interface tppf_out_if import tppf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] char_written;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, char_written, read_data, input ready);
  modport sink   (input valid, char_written, read_data, output ready);
endinterface

>>> hdl/text_pixel_page_framebuffer_unit.sv
// top level: command sequencer, font store and cursor around the frame store
// depends on tppf_pkg, tppf_if and tppf_frame_rmw
//
// one item at a time; a character draws one pixel a cycle through the frame
// store read-modify-write pipe, plus one font store read per glyph row
// reset: cursor homed, font size 7 x 10, then a clearing pass over all FRAME_BYTES
// frame bytes (1024 by default) with in_ch.ready low; configuration writes still taken

module text_pixel_page_framebuffer_unit import tppf_pkg::*; #(
  parameter int PANEL_WIDTH    = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT   = PANEL_HEIGHT_DEF,
  parameter int MAX_GLYPH_ROWS = MAX_GLYPH_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tppf_in_if.sink               in_ch,
  tppf_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
  localparam int FRAME_BYTES = PANEL_WIDTH * PAGE_COUNT;
  localparam int FB_W        = $clog2(FRAME_BYTES);
  localparam int FONT_WORDS  = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int FA_W        = $clog2(FONT_WORDS);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SWEEP = 8'b0000_0010,
    ST_PIX   = 8'b0000_0100,
    ST_CHK   = 8'b0000_1000,
    ST_FROW  = 8'b0001_0000,
    ST_DRAW  = 8'b0010_0000,
    ST_RDW   = 8'b0100_0000,
    ST_RESP  = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;

  logic [FW_W-1:0]   fw_r;
  logic [FH_W-1:0]   fh_r;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic [POS_W-1:0]  row_r, row_nxt;

  logic [CODE_W-1:0] code_r, code_nxt;
  logic [POS_W-1:0]  px_r, px_nxt;
  logic [POS_W-1:0]  py_r, py_nxt;
  logic              on_r, on_nxt;
  logic [IDX_W-1:0]  base_r, base_nxt;
  logic [FH_W-1:0]   r_r, r_nxt;
  logic [FW_W-1:0]   c_r, c_nxt;
  logic              zero_r, zero_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [CODE_W-1:0] res_wr_r, res_wr_nxt;
  logic [BYTE_W-1:0] res_rd_r, res_rd_nxt;

  logic              out_vld_r, out_vld_nxt;
  logic [CODE_W-1:0] out_wr_r, out_wr_nxt;
  logic [BYTE_W-1:0] out_rd_r, out_rd_nxt;

  // font store
  logic [FBITS_W-1:0] font_mem [FONT_WORDS];
  logic [FBITS_W-1:0] font_q_r;
  logic               font_we;
  logic               font_re;
  logic [IDX_W-1:0]   font_idx;

  // frame store side
  frm_ctl_t          frm_ctl;
  logic [FB_W-1:0]   frm_addr;
  logic [BYTE_W-1:0] frm_rdata;
  logic              frm_busy;

  logic              in_fire;
  cmd_t              cmd;
  logic [POS_W-1:0]  pix_x;
  logic [POS_W-1:0]  pix_y;
  logic [FB_W-1:0]   pix_addr;
  logic              last_col;
  logic              last_row;

  // input held off while a command is in progress and while the clearing pass after reset runs
  assign in_ch.ready = (state_r == ST_IDLE) && !frm_busy;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.command);

  assign out_ch.valid        = out_vld_r;
  assign out_ch.char_written = out_wr_r;
  assign out_ch.read_data    = out_rd_r;

  // pixel position and frame byte address
  always_comb begin
    if (state_r == ST_DRAW) begin
      pix_x = col_r + POS_W'(c_r);
      pix_y = row_r + POS_W'(r_r);
    end else begin
      pix_x = px_r;
      pix_y = py_r;
    end
    pix_addr = FB_W'(32'(pix_x) + 32'(pix_y[POS_W-1:3]) * PANEL_WIDTH);
    font_idx = base_r + IDX_W'(r_r);
    last_col = (6'(c_r) + 6'd1) == 6'(fw_r);
    last_row = (7'(r_r) + 7'd1) == 7'(fh_r);
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    code_nxt   = code_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    on_nxt     = on_r;
    base_nxt   = base_r;
    r_nxt      = r_r;
    c_nxt      = c_r;
    zero_nxt   = zero_r;
    rd_ok_nxt  = rd_ok_r;
    res_wr_nxt = res_wr_r;
    res_rd_nxt = res_rd_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    out_wr_nxt  = out_wr_r;
    out_rd_nxt  = out_rd_r;
    frm_ctl     = '0;
    frm_addr    = pix_addr;
    font_we     = 1'b0;
    font_re     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_wr_nxt = '0;
          res_rd_nxt = '0;
          state_nxt  = ST_RESP;
          case (cmd)
            CMD_CLEAR, CMD_FILL: begin
              frm_ctl.sweep_start = 1'b1;
              frm_ctl.sweep_fill  = (cmd == CMD_FILL);
              col_nxt   = '0;
              row_nxt   = '0;
              state_nxt = ST_SWEEP;
            end
            CMD_PIXEL_ON, CMD_PIXEL_OFF: begin
              px_nxt    = in_ch.pos_x;
              py_nxt    = in_ch.pos_y;
              on_nxt    = (cmd == CMD_PIXEL_ON);
              state_nxt = ST_PIX;
            end
            CMD_CURSOR: begin
              col_nxt = in_ch.pos_x;
              row_nxt = in_ch.pos_y;
            end
            CMD_CHAR: begin
              if (in_ch.character < {1'b0, CODE_FIRST} ||
                  in_ch.character > {1'b0, CODE_LAST}) begin
                code_nxt = CODE_SUBST;
              end else begin
                code_nxt = in_ch.character[CODE_W-1:0];
              end
              state_nxt = ST_CHK;
            end
            CMD_NEWLINE: begin
              col_nxt = '0;
              row_nxt = row_r + POS_W'(8);
            end
            CMD_SPACE: begin
              col_nxt = col_r + POS_W'(4);
            end
            CMD_FONT_LOAD: begin
              font_we = (32'(in_ch.font_address) < FONT_WORDS);
            end
            CMD_READ: begin
              frm_ctl.rd_en = 1'b1;
              frm_addr      = FB_W'(in_ch.byte_address);
              rd_ok_nxt     = (32'(in_ch.byte_address) < FRAME_BYTES);
              state_nxt     = ST_RDW;
            end
            default: begin
            end
          endcase
        end
      end

      // clearing or filling pass in progress
      ST_SWEEP: begin
        if (!frm_busy) begin
          state_nxt = ST_RESP;
        end
      end

      // single pixel, dropped when off the panel
      ST_PIX: begin
        frm_ctl.pix_vld = (32'(px_r) < PANEL_WIDTH) && (32'(py_r) < PANEL_HEIGHT);
        frm_ctl.pix_on  = on_r;
        frm_ctl.pix_bit = py_r[2:0];
        state_nxt       = ST_RESP;
      end

      // room check and glyph base
      ST_CHK: begin
        base_nxt = IDX_W'(32'(code_r - CODE_FIRST) * 32'(fh_r));
        r_nxt    = '0;
        if ((32'(col_r) + 32'(fw_r) > PANEL_WIDTH) ||
            (32'(row_r) + 32'(fh_r) > PANEL_HEIGHT)) begin
          res_wr_nxt = '0;
          state_nxt  = ST_RESP;
        end else if (fw_r == '0 || fh_r == '0) begin
          col_nxt    = col_r + POS_W'(fw_r);
          res_wr_nxt = code_r;
          state_nxt  = ST_RESP;
        end else begin
          state_nxt = ST_FROW;
        end
      end

      // fetch one glyph row
      ST_FROW: begin
        zero_nxt  = (32'(font_idx) >= FONT_WORDS);
        font_re   = 1'b1;
        c_nxt     = '0;
        state_nxt = ST_DRAW;
      end

      // one pixel of the row per cycle
      ST_DRAW: begin
        frm_ctl.pix_vld = 1'b1;
        frm_ctl.pix_on  = !zero_r && (c_r < FW_W'(16)) &&
                          ((font_q_r & (ROW_MSB >> c_r)) != '0);
        frm_ctl.pix_bit = pix_y[2:0];
        c_nxt           = c_r + 1'b1;
        if (last_col) begin
          r_nxt = r_r + 1'b1;
          if (last_row) begin
            col_nxt    = col_r + POS_W'(fw_r);
            res_wr_nxt = code_r;
            state_nxt  = ST_RESP;
          end else begin
            state_nxt = ST_FROW;
          end
        end
      end

      // frame byte arrives
      ST_RDW: begin
        res_rd_nxt = rd_ok_r ? frm_rdata : '0;
        state_nxt  = ST_RESP;
      end

      // hand result to the output register
      ST_RESP: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          out_wr_nxt  = res_wr_r;
          out_rd_nxt  = res_rd_r;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // font store ports
  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[FA_W'(in_ch.font_address)] <= in_ch.font_bits;
    end
    if (font_re) begin
      font_q_r <= font_mem[font_idx[FA_W-1:0]];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FONT_WIDTH_RST;
      fh_r <= FONT_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FONT_WIDTH:  fw_r <= cfg_data[FW_W-1:0];
        CFG_FONT_HEIGHT: fh_r <= cfg_data[FH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      col_r     <= '0;
      row_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    code_r   <= code_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    on_r     <= on_nxt;
    base_r   <= base_nxt;
    r_r      <= r_nxt;
    c_r      <= c_nxt;
    zero_r   <= zero_nxt;
    rd_ok_r  <= rd_ok_nxt;
    res_wr_r <= res_wr_nxt;
    res_rd_r <= res_rd_nxt;
    out_wr_r <= out_wr_nxt;
    out_rd_r <= out_rd_nxt;
  end

  tppf_frame_rmw #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (frm_ctl),
    .addr  (frm_addr),
    .rdata (frm_rdata),
    .busy  (frm_busy)
  );

endmodule

>>> hdl/tppf_frame_rmw.sv
// frame store memory with a two-stage pixel read-modify-write pipe and a clear/fill sweep
// depends on tppf_pkg

module tppf_frame_rmw import tppf_pkg::*; #(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
  localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8,
  localparam int FRAME_BYTES = PANEL_WIDTH * PAGE_COUNT,
  localparam int FB_W        = $clog2(FRAME_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  frm_ctl_t          ctl,
  input  logic [FB_W-1:0]   addr,
  output logic [BYTE_W-1:0] rdata,
  output logic              busy
);

  logic [BYTE_W-1:0] mem [FRAME_BYTES];
  logic [BYTE_W-1:0] mem_q_r;

  // pixel write stage
  logic              b_vld_r;
  logic [FB_W-1:0]   b_addr_r;
  logic [2:0]        b_bit_r;
  logic              b_on_r;

  // last written byte, covers the read that raced the write
  logic              fwd_vld_r;
  logic [FB_W-1:0]   fwd_addr_r;
  logic [BYTE_W-1:0] fwd_data_r;

  // sweep
  logic              sweep_act_r;
  logic [FB_W-1:0]   sweep_cnt_r;
  logic [BYTE_W-1:0] sweep_val_r;

  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] mask;
  logic [BYTE_W-1:0] new_byte;

  // modify
  always_comb begin
    cur_byte = (fwd_vld_r && (fwd_addr_r == b_addr_r)) ? fwd_data_r : mem_q_r;
    mask     = BYTE_W'(1) << b_bit_r;
    new_byte = b_on_r ? (cur_byte | mask) : (cur_byte & ~mask);
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (sweep_act_r) begin
      mem[sweep_cnt_r] <= sweep_val_r;
    end else if (b_vld_r) begin
      mem[b_addr_r] <= new_byte;
    end
    if (ctl.rd_en || ctl.pix_vld) begin
      mem_q_r <= mem[addr];
    end
  end

  // pipe payload
  always_ff @(posedge clk) begin
    b_addr_r   <= addr;
    b_bit_r    <= ctl.pix_bit;
    b_on_r     <= ctl.pix_on;
    fwd_addr_r <= b_addr_r;
    fwd_data_r <= new_byte;
  end

  // pipe control and sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r     <= 1'b0;
      fwd_vld_r   <= 1'b0;
      sweep_act_r <= 1'b1;
      sweep_cnt_r <= '0;
      sweep_val_r <= '0;
    end else begin
      b_vld_r   <= ctl.pix_vld;
      fwd_vld_r <= b_vld_r && !sweep_act_r;
      if (ctl.sweep_start) begin
        sweep_act_r <= 1'b1;
        sweep_cnt_r <= '0;
        sweep_val_r <= ctl.sweep_fill ? {BYTE_W{1'b1}} : '0;
      end else if (sweep_act_r) begin
        if (sweep_cnt_r == FB_W'(FRAME_BYTES - 1)) begin
          sweep_act_r <= 1'b0;
        end
        sweep_cnt_r <= sweep_cnt_r + 1'b1;
      end
    end
  end

  assign rdata = mem_q_r;
  assign busy  = sweep_act_r;

endmodule

>>> tb/text_pixel_page_framebuffer_unit_tb.sv
// self-checking testbench for the page framebuffer with character generator
// depends on tppf_pkg, tppf_if and the text_pixel_page_framebuffer_unit rtl
// a local frame, font and cursor model predicts every result item

`timescale 1ns / 1ps

module text_pixel_page_framebuffer_unit_tb;
  import tppf_pkg::*;

  localparam int PANEL_W     = PANEL_WIDTH_DEF;
  localparam int PANEL_H     = PANEL_HEIGHT_DEF;
  localparam int FRAME_BYTES = PANEL_W * ((PANEL_H + 7) / 8);
  localparam int FONT_WORDS  = GLYPH_COUNT * MAX_GLYPH_ROWS_DEF;
  localparam int FB_W        = $clog2(FRAME_BYTES);
  localparam int FA_W        = $clog2(FONT_WORDS);

  // command codes the block does not decode
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

  localparam logic [CHAR_W-1:0] CHAR_A = "A";

  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 64;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [CHAR_W-1:0]  code;
    logic [FADDR_W-1:0] faddr;
    logic [FBITS_W-1:0] fbits;
    logic [BADDR_W-1:0] baddr;
  } fb_cmd_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [BYTE_W-1:0] data;
  } fb_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tppf_in_if  in_ch ();
  tppf_out_if out_ch ();

  text_pixel_page_framebuffer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted block state
  logic [BYTE_W-1:0]  frame_mem [FRAME_BYTES];
  logic [FBITS_W-1:0] glyph_mem [FONT_WORDS];
  bit                 glyph_loaded [FONT_WORDS];
  logic [POS_W-1:0]   cur_col;
  logic [POS_W-1:0]   cur_row;
  logic [FW_W-1:0]    font_w;
  logic [FH_W-1:0]    font_h;

  fb_result_t expected_results [$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side ready, random stalls plus long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin : check_results
    fb_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual char_written %0d read_data %0d",
                 $time, out_ch.char_written, out_ch.read_data);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.char_written !== want.code) begin
          $display("%0t: char_written expected %0d actual %0d",
                   $time, want.code, out_ch.char_written);
          mismatch_count++;
        end
        if (out_ch.read_data !== want.data) begin
          $display("%0t: read_data expected %0h actual %0h",
                   $time, want.data, out_ch.read_data);
          mismatch_count++;
        end
      end
    end
  end

  function automatic void plot_pixel(int px, int py, bit on);
    int addr;
    if (px >= PANEL_W || py >= PANEL_H) return;
    addr = px + (py / 8) * PANEL_W;
    frame_mem[FB_W'(addr)][3'(py % 8)] = on;
  endfunction

  // update the predicted state for one command and return its result
  function automatic fb_result_t apply_command(fb_cmd_t it);
    fb_result_t         res;
    int                 code;
    int                 base;
    int                 idx;
    bit                 on;
    logic [FBITS_W-1:0] bits;
    res = '0;
    case (it.cmd)
      CMD_CLEAR, CMD_FILL: begin
        foreach (frame_mem[i]) frame_mem[i] = (it.cmd == CMD_FILL) ? '1 : '0;
        cur_col = '0;
        cur_row = '0;
      end
      CMD_PIXEL_ON:  plot_pixel(int'(it.x), int'(it.y), 1'b1);
      CMD_PIXEL_OFF: plot_pixel(int'(it.x), int'(it.y), 1'b0);
      CMD_CURSOR: begin
        cur_col = it.x;
        cur_row = it.y;
      end
      CMD_CHAR: begin
        code = int'(it.code);
        if (code < int'(CODE_FIRST) || code > int'(CODE_LAST)) code = int'(CODE_SUBST);
        // refused when the glyph would run past the right or bottom edge
        if (int'(cur_col) + int'(font_w) <= PANEL_W &&
            int'(cur_row) + int'(font_h) <= PANEL_H) begin
          base = (code - int'(CODE_FIRST)) * int'(font_h);
          for (int r = 0; r < int'(font_h); r++) begin
            idx = base + r;
            bits = (idx < FONT_WORDS) ? glyph_mem[FA_W'(idx)] : '0;
            for (int c = 0; c < int'(font_w); c++) begin
              // columns past the glyph row width are black
              on = 1'b0;
              if (c < FBITS_W) on = bits[4'(FBITS_W - 1 - c)];
              plot_pixel(int'(cur_col) + c, int'(cur_row) + r, on);
            end
          end
          cur_col = cur_col + POS_W'(font_w);
          res.code = code[CODE_W-1:0];
        end
      end
      CMD_NEWLINE: begin
        cur_col = '0;
        cur_row = cur_row + 8'd8;
      end
      CMD_SPACE: cur_col = cur_col + 8'd4;
      CMD_FONT_LOAD: begin
        if (int'(it.faddr) < FONT_WORDS) begin
          glyph_mem[it.faddr]    = it.fbits;
          glyph_loaded[it.faddr] = 1'b1;
        end
      end
      CMD_READ:      if (int'(it.baddr) < FRAME_BYTES) res.data = frame_mem[it.baddr];
      default: ;
    endcase
    return res;
  endfunction

  function automatic fb_cmd_t random_fields(logic [CMD_W-1:0] cmd);
    fb_cmd_t it;
    it.cmd   = cmd;
    it.x     = POS_W'($urandom);
    it.y     = POS_W'($urandom);
    it.code  = CHAR_W'($urandom);
    it.faddr = FADDR_W'($urandom);
    it.fbits = FBITS_W'($urandom);
    it.baddr = BADDR_W'($urandom);
    return it;
  endfunction

  // character codes drawn in random traffic: unprintable ones, both ends and one letter
  function automatic logic [CHAR_W-1:0] pick_code();
    logic [CHAR_W-1:0] ch;
    case ($urandom_range(4))
      0: ch = CHAR_W'($urandom_range(int'(CODE_FIRST) - 1));
      1: ch = CHAR_W'($urandom_range(255, int'(CODE_LAST) + 1));
      2: ch = {1'b0, CODE_FIRST};
      3: ch = {1'b0, CODE_LAST};
      default: ch = CHAR_A;
    endcase
    return ch;
  endfunction

  // offer one item, wait for its handshake, then predict its result
  task automatic send_item(input fb_cmd_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= it.cmd;
    in_ch.pos_x        <= it.x;
    in_ch.pos_y        <= it.y;
    in_ch.character    <= it.code;
    in_ch.font_address <= it.faddr;
    in_ch.font_bits    <= it.fbits;
    in_ch.byte_address <= it.baddr;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    expected_results.push_back(apply_command(it));
  endtask

  task automatic put_cmd(input logic [CMD_W-1:0] cmd, input int px, input int py);
    fb_cmd_t it;
    it = random_fields(cmd);
    it.x = POS_W'(px);
    it.y = POS_W'(py);
    send_item(it);
  endtask

  task automatic draw_char(input logic [CHAR_W-1:0] ch);
    fb_cmd_t it;
    it = random_fields(CMD_CHAR);
    it.code = ch;
    send_item(it);
  endtask

  task automatic read_byte(input int addr);
    fb_cmd_t it;
    it = random_fields(CMD_READ);
    it.baddr = BADDR_W'(addr);
    send_item(it);
  endtask

  task automatic load_font(input int addr, input logic [FBITS_W-1:0] bits);
    fb_cmd_t it;
    it = random_fields(CMD_FONT_LOAD);
    it.faddr = FADDR_W'(addr);
    it.fbits = bits;
    send_item(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_FONT_WIDTH) font_w = val[FW_W-1:0];
    else font_h = val[FH_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop offering and let every pending result come out
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random traffic: text bursts with random glyphs, mixed with single commands
  task automatic run_random(input int n_items);
    fb_cmd_t          it;
    logic [CMD_W-1:0] pick;
    int               done;
    int               w;
    int               n_chars;
    int               start_col;
    int               start_page;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 25) begin
        // cursor where a glyph fits, a few characters, then reads over them
        it = random_fields(CMD_CURSOR);
        it.x = POS_W'($urandom_range(PANEL_W - int'(font_w)));
        it.y = POS_W'($urandom_range(PANEL_H - int'(font_h)));
        send_item(it);
        start_col = int'(it.x);
        start_page = int'(it.y) / 8;
        n_chars = $urandom_range(3, 1);
        repeat (n_chars) begin
          it = random_fields(CMD_CHAR);
          it.code = pick_code();
          send_item(it);
        end
        repeat (2) begin
          it = random_fields(CMD_READ);
          it.baddr = BADDR_W'(start_col + int'($urandom_range(int'(font_w) * n_chars)) +
                     (start_page + int'($urandom_range(int'(font_h) / 8))) * PANEL_W);
          send_item(it);
        end
        done += n_chars + 3;
      end else begin
        w = $urandom_range(99);
        if (w < 1)       pick = CMD_CLEAR;
        else if (w < 2)  pick = CMD_FILL;
        else if (w < 20) pick = CMD_PIXEL_ON;
        else if (w < 32) pick = CMD_PIXEL_OFF;
        else if (w < 42) pick = CMD_CURSOR;
        else if (w < 62) pick = CMD_CHAR;
        else if (w < 66) pick = CMD_NEWLINE;
        else if (w < 70) pick = CMD_SPACE;
        else if (w < 78) pick = CMD_FONT_LOAD;
        else if (w < 97) pick = CMD_READ;
        else pick = CMD_W'($urandom_range(int'(CMD_UNUSED_HI), int'(CMD_UNUSED_LO)));
        it = random_fields(pick);
        case (pick)
          CMD_PIXEL_ON, CMD_PIXEL_OFF: begin
            if ($urandom_range(4) != 0) begin
              it.x = POS_W'($urandom_range(PANEL_W - 1));
              it.y = POS_W'($urandom_range(PANEL_H - 1));
            end
          end
          CMD_CURSOR: begin
            if ($urandom_range(2) != 0) begin
              it.x = POS_W'($urandom_range(PANEL_W - int'(font_w)));
              it.y = POS_W'($urandom_range(PANEL_H - int'(font_h)));
            end
          end
          CMD_CHAR:
            it.code = pick_code();
          CMD_FONT_LOAD:
            if ($urandom_range(9) != 0) it.faddr = FADDR_W'($urandom_range(FONT_WORDS - 1));
          CMD_READ:
            // bias reads toward the bytes around the cursor
            if ($urandom_range(1))
              it.baddr = BADDR_W'(int'(cur_col) - int'($urandom_range(16)) +
                         (int'(cur_row) / 8 + int'($urandom_range(1))) * PANEL_W);
          default: ;
        endcase
        send_item(it);
        if (pick <= CMD_READ) done++;
      end
    end
  endtask

  // every glyph row that a drawn character can reach at the current height gets a value
  task automatic test_font_preload();
    logic [CODE_W-1:0] glyph_codes [4];
    int                idx;
    glyph_codes = '{CODE_FIRST, CODE_SUBST, CHAR_A[CODE_W-1:0], CODE_LAST};
    foreach (glyph_codes[k]) begin
      for (int r = 0; r < int'(font_h); r++) begin
        idx = (int'(glyph_codes[k]) - int'(CODE_FIRST)) * int'(font_h) + r;
        if (idx < FONT_WORDS && !glyph_loaded[FA_W'(idx)])
          load_font(idx, FBITS_W'($urandom));
      end
    end
  endtask

  task automatic run_phase(input int fw, input int fh, input int idle_pct,
                           input int stall_pct, input int n_items);
    drain_results();
    write_reg(CFG_FONT_WIDTH, CFG_DATA_W'(fw));
    write_reg(CFG_FONT_HEIGHT, CFG_DATA_W'(fh));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    test_font_preload();
    run_random(n_items);
  endtask

  task automatic test_clear_fill();
    put_cmd(CMD_FILL, 0, 0);
    read_byte(FRAME_BYTES - 1);
    put_cmd(CMD_CLEAR, 0, 0);
    read_byte(0);
  endtask

  task automatic test_pixel_bounds();
    put_cmd(CMD_PIXEL_ON, 0, 0);
    put_cmd(CMD_PIXEL_ON, PANEL_W, 1);
    read_byte(0);
    put_cmd(CMD_PIXEL_ON, PANEL_W - 1, PANEL_H - 1);
    read_byte(FRAME_BYTES - 1);
    put_cmd(CMD_PIXEL_OFF, PANEL_W - 1, PANEL_H - 1);
    read_byte(FRAME_BYTES - 1);
  endtask

  task automatic test_font_load_bounds();
    load_font((1 << FADDR_W) - 1, '1);
    load_font(FONT_WORDS, '1);
  endtask

  task automatic test_unknown_cmds();
    put_cmd(CMD_UNUSED_LO, 0, 0);
    put_cmd(CMD_UNUSED_HI, 0, 0);
  endtask

  // substitution, wraps, exact fit and refusal at the panel edges
  task automatic test_char_cases();
    put_cmd(CMD_CURSOR, 252, 0);
    put_cmd(CMD_SPACE, 0, 0);
    draw_char(CHAR_A);
    draw_char('0);
    draw_char('1);
    draw_char({1'b0, CODE_LAST});
    draw_char({1'b0, CODE_FIRST});
    put_cmd(CMD_NEWLINE, 0, 0);
    read_byte(PANEL_W + 1);
    put_cmd(CMD_CURSOR, PANEL_W - 7, PANEL_H - 10);
    draw_char(CHAR_A);
    draw_char(CHAR_A);
    put_cmd(CMD_CURSOR, 0, 252);
    put_cmd(CMD_NEWLINE, 0, 0);
    draw_char(CHAR_A);
    read_byte(2);
  endtask

  // long receiver hold-off while commands keep coming
  task automatic test_backpressure();
    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    run_random(40);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.command      = '0;
    in_ch.pos_x        = '0;
    in_ch.pos_y        = '0;
    in_ch.character    = '0;
    in_ch.font_address = '0;
    in_ch.font_bits    = '0;
    in_ch.byte_address = '0;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    foreach (glyph_mem[i]) glyph_mem[i] = '0;
    foreach (glyph_loaded[i]) glyph_loaded[i] = 1'b0;
    cur_col = '0;
    cur_row = '0;
    font_w  = FONT_WIDTH_RST;
    font_h  = FONT_HEIGHT_RST;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_FONT_WIDTH, CFG_DATA_W'(FONT_WIDTH_RST));
    write_reg(CFG_FONT_HEIGHT, CFG_DATA_W'(FONT_HEIGHT_RST));
    test_font_preload();
    test_clear_fill();
    test_pixel_bounds();
    test_font_load_bounds();
    test_unknown_cmds();
    test_char_cases();

    // font size sweep with each idling pattern
    run_phase(7, 10, 0, 0, 60);
    run_phase(5, 8, 49, 0, 45);
    run_phase(8, 16, 0, 49, 45);
    run_phase(16, 32, 31, 31, 40);
    run_phase(1, 1, 0, 0, 40);
    run_phase(0, 0, 31, 31, 30);
    run_phase(31, 63, 49, 0, 30);
    run_phase(12, 7, 31, 49, 45);
    test_backpressure();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
